[src/ppmd_pkg.sv]
// Shared types and constants for the PPM frame decoder.
package ppmd_pkg;

	localparam int unsigned NUM_CHANNELS_DEF = 8;
	localparam int unsigned SLOT_W           = 5;
	localparam int unsigned CFG_IDX_W        = 3;
	localparam int unsigned REG_W            = 16;
	localparam int unsigned TIME_W           = 32;
	localparam int unsigned SEL_W            = 4;

	localparam logic [TIME_W-1:0] OVERFLOW_LIMIT = 32'h8000_0000;

	localparam logic [REG_W-1:0] NOISE_FLOOR_RST = 16'd200;
	localparam logic [REG_W-1:0] SYNC_THRESH_RST = 16'd3000;
	localparam logic [REG_W-1:0] MIN_VALID_RST   = 16'd800;
	localparam logic [REG_W-1:0] MAX_VALID_RST   = 16'd2200;
	localparam logic [REG_W-1:0] NEUTRAL_RST     = 16'd1500;

	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THRESH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL     = 3'd4;

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		EV_NOISE    = 3'd0,
		EV_OVERFLOW = 3'd1,
		EV_SYNC     = 3'd2,
		EV_STORED   = 3'd3,
		EV_REJECTED = 3'd4,
		EV_FULL     = 3'd5,
		EV_READ     = 3'd6
	} event_t;

	typedef struct packed {
		logic [REG_W-1:0] noise_floor;
		logic [REG_W-1:0] sync_thresh;
		logic [REG_W-1:0] min_valid;
		logic [REG_W-1:0] max_valid;
		logic [REG_W-1:0] neutral;
	} cfg_t;

	typedef struct packed {
		event_t code;
		logic   take_edge;
		logic   store;
		logic   restart;
	} cls_t;

endpackage

[src/ppm_frame_decoder_core.sv]
// PPM frame decoder top level: input stage, decode stage, channel store.
// An accepted item is registered in the input stage, its result in the decode stage.
// Throughput: one item per cycle; the decode stage holds only while its
// result waits to be taken.
// Reset: asynchronous, active low; thresholds return to their defaults,
// the reference time and slot counter clear, every channel holds 1500.
module ppm_frame_decoder_core import ppmd_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_wdata,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic                 operation,
	input  logic [TIME_W-1:0]    edge_time_us,
	input  logic [SEL_W-1:0]     channel_select,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [2:0]           event_code,
	output logic [SEL_W-1:0]     channel_index,
	output logic [TIME_W-1:0]    pulse_width_us,
	output logic [REG_W-1:0]     channel_value
);

	localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [SLOT_W-1:0] NUM_CH = SLOT_W'(NUM_CHANNELS);

	cfg_t              cfg_q;
	logic [TIME_W-1:0] last_edge_q;
	logic [SLOT_W-1:0] slot_q;
	logic [REG_W-1:0]  store_q [NUM_CHANNELS];

	logic              valid_s1;
	logic              op_s1;
	logic [TIME_W-1:0] time_s1;
	logic [SEL_W-1:0]  sel_s1;

	logic              en_s1;
	logic              en_s2;
	logic              fire;

	logic [TIME_W-1:0] width;
	cls_t              cls;
	logic              sel_in_range;
	logic [REG_W-1:0]  read_value;

	event_t            code_d;
	logic [SEL_W-1:0]  idx_d;
	logic [TIME_W-1:0] width_d;
	logic [REG_W-1:0]  value_d;

	event_t            code_s2;

	assign en_s2      = !result_valid || result_ready;
	assign en_s1      = !valid_s1 || en_s2;
	assign item_ready = en_s1;
	assign fire       = valid_s1 && en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{noise_floor: NOISE_FLOOR_RST, sync_thresh: SYNC_THRESH_RST,
			           min_valid: MIN_VALID_RST, max_valid: MAX_VALID_RST,
			           neutral: NEUTRAL_RST};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NOISE_FLOOR: cfg_q.noise_floor <= cfg_wdata;
				CFG_SYNC_THRESH: cfg_q.sync_thresh <= cfg_wdata;
				CFG_MIN_VALID:   cfg_q.min_valid   <= cfg_wdata;
				CFG_MAX_VALID:   cfg_q.max_valid   <= cfg_wdata;
				CFG_NEUTRAL:     cfg_q.neutral     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && item_valid) begin
			op_s1   <= operation;
			time_s1 <= edge_time_us;
			sel_s1  <= channel_select;
		end
	end

	assign width = time_s1 - last_edge_q;

	ppmd_classify #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_classify (
		.pulse_width(width),
		.slot       (slot_q),
		.cfg        (cfg_q),
		.cls        (cls)
	);

	assign sel_in_range = {1'b0, sel_s1} < NUM_CH;
	assign read_value   = sel_in_range ? store_q[sel_s1[IDX_W-1:0]] : cfg_q.neutral;

	always_comb begin
		unique case (op_s1)
			OP_READ: begin
				code_d  = EV_READ;
				idx_d   = sel_s1;
				width_d = '0;
				value_d = read_value;
			end
			OP_EDGE: begin
				code_d  = cls.code;
				idx_d   = cls.store ? slot_q[SEL_W-1:0] : '0;
				width_d = width;
				value_d = cls.store ? width[REG_W-1:0] : '0;
			end
			default: begin
				code_d  = EV_NOISE;
				idx_d   = '0;
				width_d = '0;
				value_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			slot_q      <= '0;
		end else if (fire && op_s1 == OP_EDGE) begin
			if (cls.take_edge) begin
				last_edge_q <= time_s1;
			end
			if (cls.restart) begin
				slot_q <= '0;
			end else if (cls.store) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				store_q[i] <= NEUTRAL_RST;
			end
		end else if (fire && op_s1 == OP_EDGE && cls.store) begin
			store_q[slot_q[IDX_W-1:0]] <= width[REG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en_s2) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			code_s2        <= code_d;
			channel_index  <= idx_d;
			pulse_width_us <= width_d;
			channel_value  <= value_d;
		end
	end

	assign event_code = code_s2;

	a_slot_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= NUM_CH)
		else $error("slot counter beyond frame length");

	a_store_index: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && code_s2 == EV_STORED) |-> ({1'b0, channel_index} < NUM_CH))
		else $error("stored transaction names a slot outside the frame");

	a_read_width: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && code_s2 == EV_READ) |-> (pulse_width_us == '0))
		else $error("read reply carries a pulse width");

	a_sync_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_s1 == OP_EDGE && cls.code == EV_SYNC) |=> (slot_q == '0))
		else $error("sync gap did not restart the slot counter");

	a_noise_keeps_ref: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && op_s1 == OP_EDGE && cls.code == EV_NOISE) |=> $stable(last_edge_q))
		else $error("noise edge moved the reference time");

endmodule

[src/ppmd_classify.sv]
// Edge interval classification against the configured thresholds.
module ppmd_classify import ppmd_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic [TIME_W-1:0] pulse_width,
	input  logic [SLOT_W-1:0] slot,
	input  cfg_t              cfg,
	output cls_t              cls
);

	localparam logic [SLOT_W-1:0] NUM_CH = SLOT_W'(NUM_CHANNELS);

	logic is_noise;
	logic is_overflow;
	logic is_sync;
	logic in_range;
	logic has_room;

	assign is_noise    = pulse_width < {16'd0, cfg.noise_floor};
	assign is_overflow = pulse_width > OVERFLOW_LIMIT;
	assign is_sync     = pulse_width > {16'd0, cfg.sync_thresh};
	assign in_range    = (pulse_width >= {16'd0, cfg.min_valid}) &&
	                     (pulse_width <= {16'd0, cfg.max_valid});
	assign has_room    = slot < NUM_CH;

	always_comb begin
		cls = '{code: EV_NOISE, take_edge: 1'b0, store: 1'b0, restart: 1'b0};
		priority if (is_noise) begin
			cls.code = EV_NOISE;
		end else if (is_overflow) begin
			cls.code      = EV_OVERFLOW;
			cls.take_edge = 1'b1;
		end else if (is_sync) begin
			cls.code      = EV_SYNC;
			cls.take_edge = 1'b1;
			cls.restart   = 1'b1;
		end else if (has_room && in_range) begin
			cls.code      = EV_STORED;
			cls.take_edge = 1'b1;
			cls.store     = 1'b1;
		end else if (has_room) begin
			cls.code      = EV_REJECTED;
			cls.take_edge = 1'b1;
		end else begin
			cls.code      = EV_FULL;
			cls.take_edge = 1'b1;
		end
	end

endmodule
